>>> sv/lsd_pkg.sv
package lsd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  localparam logic REQ_PUSH   = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic compare;
    logic push;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> sv/list_store_with_capacity_doubling_unit.sv
// Packed list store built as a row of cells, one stored entry per cell. A push
// appends a value; a delete removes the last stored occurrence of a value and
// the cells above it shift down one place. Each item answers with a status,
// the entry count and the logical capacity. An item passes a compare step, in
// which every cell compares its entry with the value at once, and then an
// update step, in which the cells write or shift and the result is registered;
// the next item is taken in the update step. The search across cells is a
// suffix OR passed down the row from the top cell. A result held by a stalled
// output delays the update cycle until the output register frees.
module list_store_with_capacity_doubling_unit #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         entry_count,
  output logic [7:0]         capacity
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  lsd_pkg::cell_ctrl_t   cell_ctrl;
  logic                  found;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cap;
  logic [DATA_WIDTH-1:0] req_value;
  logic [DATA_WIDTH-1:0] entry_bus [DEPTH];
  logic                  above [DEPTH+1];

  lsd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .capacity    (capacity),
    .cell_ctrl   (cell_ctrl),
    .found       (found),
    .count       (count),
    .cap         (cap),
    .req_value   (req_value)
  );

  assign above[DEPTH] = 1'b0;
  assign found        = above[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;

    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = entry_bus[i+1];
    end

    lsd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .count       (count),
      .value       (req_value),
      .upper_entry (upper),
      .above_in    (above[i+1]),
      .entry       (entry_bus[i]),
      .above_out   (above[i])
    );
  end

  a_count_within_cap: assert property (@(posedge clk) disable iff (rst)
    (count <= cap) && (cap <= CNT_W'(DEPTH)))
    else $error("entry count exceeds capacity or capacity exceeds depth");

  a_accept_then_compare: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cell_ctrl.compare)
    else $error("accepted item was not followed by a compare cycle");

  a_shift_decrements: assert property (@(posedge clk) disable iff (rst)
    cell_ctrl.shift |=> (count == $past(count) - 1'b1))
    else $error("removal did not decrement the entry count");

  a_push_shift_exclusive: assert property (@(posedge clk) disable iff (rst)
    cell_ctrl.shift |-> (found && !cell_ctrl.push))
    else $error("shift without a match or together with a push");

endmodule

>>> sv/lsd_cell.sv
module lsd_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 8,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  lsd_pkg::cell_ctrl_t   ctrl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] upper_entry,
  input  logic                  above_in,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  above_out
);

  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

  logic match;
  logic occupied;

  assign occupied  = MY_INDEX < count;
  assign above_out = above_in | match;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= occupied && (entry == value);
    end
  end

  // A cell at or above the removed entry takes its upper neighbor's value.
  always_ff @(posedge clk) begin
    if (ctrl.push && (MY_INDEX == count)) begin
      entry <= value;
    end else if (ctrl.shift && !above_in) begin
      entry <= upper_entry;
    end
  end

endmodule

>>> sv/lsd_ctrl.sv
module lsd_ctrl #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic signed [31:0]    item_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [7:0]            entry_count,
  output logic [7:0]            capacity,
  output lsd_pkg::cell_ctrl_t   cell_ctrl,
  input  logic                  found,
  output logic [CNT_W-1:0]      count,
  output logic [CNT_W-1:0]      cap,
  output logic [DATA_WIDTH-1:0] req_value
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_W = (CNT_W + 1)'(DEPTH);

  lsd_pkg::state_t state, state_next;

  logic                  req_kind;
  logic                  advance;
  logic                  accept;
  logic                  commit;
  logic                  full;
  logic                  push_ok;
  logic                  del_ok;
  logic [CNT_W-1:0]      count_dec;
  logic [CNT_W:0]        cap_dbl;
  logic [CNT_W-1:0]      cap_grow;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      cap_next;
  logic [1:0]            status_next;
  logic [CNT_W+7:0]      count_ext;
  logic [CNT_W+7:0]      cap_ext;
  logic [DATA_WIDTH+31:0] value_ext;

  assign advance   = !out_valid || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign commit    = (state == lsd_pkg::ST_UPDATE) && advance;
  assign value_ext = {{DATA_WIDTH{1'b0}}, item_value};

  always_comb begin
    state_next = state;
    unique case (state)
      lsd_pkg::ST_IDLE: begin
        if (in_valid) state_next = lsd_pkg::ST_SEARCH;
      end
      lsd_pkg::ST_SEARCH: begin
        state_next = lsd_pkg::ST_UPDATE;
      end
      lsd_pkg::ST_UPDATE: begin
        if (advance) begin
          state_next = in_valid ? lsd_pkg::ST_SEARCH : lsd_pkg::ST_IDLE;
        end
      end
      default: state_next = lsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall          = 1'b1;
    cell_ctrl.compare = 1'b0;
    cell_ctrl.push    = 1'b0;
    cell_ctrl.shift   = 1'b0;
    unique case (state)
      lsd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      lsd_pkg::ST_SEARCH: begin
        cell_ctrl.compare = 1'b1;
      end
      lsd_pkg::ST_UPDATE: begin
        in_stall        = !advance;
        cell_ctrl.push  = advance && push_ok;
        cell_ctrl.shift = advance && del_ok;
      end
      default: ;
    endcase
  end

  // Result of the request held in the update state.
  always_comb begin
    full      = count == DEPTH_C;
    push_ok   = (req_kind == lsd_pkg::REQ_PUSH) && !full;
    del_ok    = (req_kind == lsd_pkg::REQ_DELETE) && (count != '0) && found;
    count_dec = count - 1'b1;
    cap_dbl   = {cap, 1'b0};

    if (cap == '0) begin
      cap_grow = CNT_W'(1);
    end else if (count >= cap) begin
      cap_grow = (cap_dbl > DEPTH_W) ? DEPTH_C : cap_dbl[CNT_W-1:0];
    end else begin
      cap_grow = cap;
    end

    count_next  = count;
    cap_next    = cap;
    status_next = lsd_pkg::STATUS_OK;
    if (req_kind == lsd_pkg::REQ_PUSH) begin
      if (full) begin
        status_next = lsd_pkg::STATUS_FULL;
      end else begin
        count_next = count + 1'b1;
        cap_next   = cap_grow;
      end
    end else if (count == '0) begin
      status_next = lsd_pkg::STATUS_EMPTY;
    end else if (!found) begin
      status_next = lsd_pkg::STATUS_NOT_FOUND;
    end else begin
      count_next = count_dec;
      if ({1'b0, cap} == {count_dec, 1'b0}) begin
        cap_next = cap >> 1;
      end
    end
  end

  assign count_ext = {8'd0, count_next};
  assign cap_ext   = {8'd0, cap_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsd_pkg::ST_IDLE;
      count     <= '0;
      cap       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        cap       <= cap_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= req_type;
      req_value <= value_ext[DATA_WIDTH-1:0];
    end
    if (commit) begin
      status      <= status_next;
      entry_count <= count_ext[7:0];
      capacity    <= cap_ext[7:0];
    end
  end

endmodule
